// ===== hdl/mrlsd_pkg.sv =====
package mrlsd_pkg;

  localparam int unsigned CfgW  = 11;
  localparam int unsigned PosW  = 10;
  localparam int unsigned ByteW = 8;
  localparam int unsigned RunW  = 10;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam logic [CfgW-1:0] MaxDim        = 11'd1024;
  localparam logic [CfgW-1:0] ShortExtWidth = 11'd320;

  localparam logic [CfgW-1:0] FrameWidthRst  = 11'd320;
  localparam logic [CfgW-1:0] FrameHeightRst = 11'd200;
  localparam logic [CfgW-1:0] WinWidthRst    = 11'd320;
  localparam logic [CfgW-1:0] WinHeightRst   = 11'd200;

  localparam logic [RunW-1:0] RunExtBase   = 10'd255;
  localparam logic [RunW-1:0] RunLongBase  = 10'd256;
  localparam logic [RunW-1:0] RunThirdBase = 10'd511;
  localparam logic [ByteW-1:0] ByteMax     = 8'd255;

  typedef enum logic [1:0] {
    KIND_SPAN = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_PARITY = 2'd0,
    PH_RUN    = 2'd1,
    PH_EXT    = 2'd2,
    PH_THIRD  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_WIN_X        = 3'd2,
    REG_WIN_Y        = 3'd3,
    REG_WIN_WIDTH    = 3'd4,
    REG_WIN_HEIGHT   = 3'd5
  } reg_e;

  typedef struct packed {
    logic [CfgW-1:0] frame_width;
    logic [CfgW-1:0] frame_height;
    logic [CfgW-1:0] win_x;
    logic [CfgW-1:0] win_y;
    logic [CfgW-1:0] win_width;
    logic [CfgW-1:0] win_height;
  } cfg_t;

  typedef struct packed {
    kind_e           kind;
    logic [PosW-1:0] row;
    logic [PosW-1:0] column;
    logic [CfgW-1:0] span_length;
  } result_t;

  // results caused by one mask byte, in delivery order
  typedef struct packed {
    logic    any;
    logic    two;
    result_t first;
    result_t second;
  } pair_t;

endpackage

// ===== hdl/mrlsd_cfg.sv =====
module mrlsd_cfg import mrlsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t            cfg_q, cfg_d;
  reg_e            reg_sel;
  logic            wr_en;
  logic [CfgW-1:0] wr_val;
  logic [CfgW-1:0] rd_val;

  assign reg_sel = reg_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign wr_val  = pwdata[CfgW-1:0];
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_FRAME_WIDTH:  cfg_d.frame_width  = wr_val;
        REG_FRAME_HEIGHT: cfg_d.frame_height = wr_val;
        REG_WIN_X:        cfg_d.win_x        = wr_val;
        REG_WIN_Y:        cfg_d.win_y        = wr_val;
        REG_WIN_WIDTH:    cfg_d.win_width    = wr_val;
        REG_WIN_HEIGHT:   cfg_d.win_height   = wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FRAME_WIDTH:  rd_val = cfg_q.frame_width;
      REG_FRAME_HEIGHT: rd_val = cfg_q.frame_height;
      REG_WIN_X:        rd_val = cfg_q.win_x;
      REG_WIN_Y:        rd_val = cfg_q.win_y;
      REG_WIN_WIDTH:    rd_val = cfg_q.win_width;
      REG_WIN_HEIGHT:   rd_val = cfg_q.win_height;
      default:          rd_val = '0;
    endcase
  end

  assign prdata = {{(DataW-CfgW){1'b0}}, rd_val};
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= FrameWidthRst;
      cfg_q.frame_height <= FrameHeightRst;
      cfg_q.win_x        <= '0;
      cfg_q.win_y        <= '0;
      cfg_q.win_width    <= WinWidthRst;
      cfg_q.win_height   <= WinHeightRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hdl/mrlsd_decode.sv =====
module mrlsd_decode import mrlsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             fire_i,
  input  logic [ByteW-1:0] mask_byte_i,
  input  logic             end_of_mask_i,
  output pair_t            pair_o
);

  phase_e           phase_q, phase_d;
  logic [CfgW-1:0]  rows_q, rows_d;
  logic [CfgW-1:0]  col_q, col_d;
  logic [ByteW-1:0] par_q, par_d;
  logic             status_q, status_d;

  logic             win_ok, rows_full, dec_on;
  logic [CfgW:0]    x_end, y_end;
  logic [ByteW-1:0] b_inc;
  logic             have_run;
  logic [RunW-1:0]  run;
  phase_e           phase_step;
  logic [CfgW-1:0]  rem, vis, col_sum, run_ext;
  logic             row_done, span_hit, rows_end;
  logic [CfgW-1:0]  col_step, rows_step, col_fin;
  phase_e           phase_run, phase_fin;
  logic [ByteW-1:0] par_step;
  logic             span_valid, status_valid;
  kind_e            status_kind;
  logic [CfgW-1:0]  row_abs, col_abs;
  result_t          span_res, status_res;

  assign x_end = {1'b0, cfg_i.win_x} + {1'b0, cfg_i.win_width};
  assign y_end = {1'b0, cfg_i.win_y} + {1'b0, cfg_i.win_height};
  assign win_ok = !(cfg_i.frame_width > MaxDim || cfg_i.frame_height > MaxDim ||
                    cfg_i.win_x > cfg_i.frame_width || cfg_i.win_y > cfg_i.frame_height ||
                    x_end > {1'b0, cfg_i.frame_width} ||
                    y_end > {1'b0, cfg_i.frame_height});
  assign rows_full = rows_q >= cfg_i.win_height;
  assign dec_on    = win_ok && !rows_full;

  assign b_inc = 8'(mask_byte_i + 8'd1);

  always_comb begin
    have_run   = 1'b0;
    run        = '0;
    phase_step = phase_q;
    unique case (phase_q)
      PH_PARITY: ;
      PH_RUN: begin
        if (mask_byte_i != '0) begin
          have_run = 1'b1;
          run      = {2'b00, mask_byte_i};
        end else begin
          phase_step = PH_EXT;
        end
      end
      PH_EXT: begin
        if (cfg_i.frame_width == ShortExtWidth) begin
          have_run = 1'b1;
          run      = RunExtBase + {2'b00, b_inc};
        end else if (mask_byte_i == ByteMax) begin
          have_run = 1'b1;
          run      = RunThirdBase;
        end else if (mask_byte_i != '0) begin
          have_run = 1'b1;
          run      = RunLongBase + {2'b00, mask_byte_i};
        end else begin
          phase_step = PH_THIRD;
        end
      end
      PH_THIRD: begin
        have_run = 1'b1;
        run      = RunThirdBase + {2'b00, b_inc};
      end
      default: ;
    endcase
  end

  assign rem     = (col_q < cfg_i.win_width) ? 11'(cfg_i.win_width - col_q) : '0;
  assign run_ext = {1'b0, run};
  assign vis     = (run_ext < rem) ? run_ext : rem;
  assign col_sum = 11'(col_q + vis);

  always_comb begin
    row_done  = 1'b0;
    col_step  = col_q;
    phase_run = phase_step;
    par_step  = par_q;
    if (phase_q == PH_PARITY) begin
      par_step = mask_byte_i;
      col_step = '0;
      if (cfg_i.win_width == '0) begin
        row_done = 1'b1;
      end else begin
        phase_run = PH_RUN;
      end
    end
    if (have_run) begin
      col_step = col_sum;
      par_step = 8'(8'd0 - par_q);
      if (col_sum >= cfg_i.win_width) begin
        row_done = 1'b1;
      end else begin
        phase_run = PH_RUN;
      end
    end
  end

  assign span_hit  = have_run && !par_q[ByteW-1] && (vis != '0);
  assign rows_step = row_done ? 11'(rows_q + 11'd1) : rows_q;
  assign phase_fin = row_done ? PH_PARITY : phase_run;
  assign col_fin   = row_done ? '0 : col_step;
  assign rows_end  = row_done && (rows_step >= cfg_i.win_height);

  // next state
  always_comb begin
    phase_d  = phase_q;
    rows_d   = rows_q;
    col_d    = col_q;
    par_d    = par_q;
    status_d = status_q;
    if (fire_i) begin
      priority if (end_of_mask_i) begin
        phase_d  = PH_PARITY;
        rows_d   = '0;
        col_d    = '0;
        par_d    = '0;
        status_d = 1'b0;
      end else if (status_q) begin
        status_d = 1'b1;
      end else if (!dec_on) begin
        status_d = 1'b1;
      end else begin
        phase_d  = phase_fin;
        rows_d   = rows_step;
        col_d    = col_fin;
        par_d    = par_step;
        status_d = rows_end;
      end
    end
  end

  // results
  assign row_abs = 11'(cfg_i.win_y + rows_q);
  assign col_abs = 11'(cfg_i.win_x + col_q);

  always_comb begin
    span_valid   = !status_q && dec_on && span_hit;
    status_valid = !status_q && (!dec_on || rows_end || end_of_mask_i);
    priority if (!win_ok) begin
      status_kind = KIND_ERR;
    end else if (rows_full || rows_end) begin
      status_kind = KIND_OK;
    end else if (phase_fin == PH_PARITY) begin
      status_kind = KIND_OK;
    end else begin
      status_kind = KIND_ERR;
    end

    span_res.kind        = KIND_SPAN;
    span_res.row         = row_abs[PosW-1:0];
    span_res.column      = col_abs[PosW-1:0];
    span_res.span_length = vis;

    status_res.kind        = status_kind;
    status_res.row         = '0;
    status_res.column      = '0;
    status_res.span_length = '0;

    pair_o.any    = span_valid || status_valid;
    pair_o.two    = span_valid && status_valid;
    pair_o.first  = span_valid ? span_res : status_res;
    pair_o.second = status_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_PARITY;
      rows_q   <= '0;
      col_q    <= '0;
      par_q    <= '0;
      status_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      rows_q   <= rows_d;
      col_q    <= col_d;
      par_q    <= par_d;
      status_q <= status_d;
    end
  end

endmodule

// ===== hdl/mask_run_length_span_decoder.sv =====
// Run-length mask decoder: takes one coded mask byte per cycle unless stalled
// and delivers spans to clear (absolute row, column, clipped length) plus one
// ok or error status per mask, one result per cycle unless the output stalls.
// A byte is decoded in the cycle it is accepted; its results (zero, one or
// two) go to the output register, or to the skid register while the output
// register is busy; a span and status from one byte go out span first.
// The one-deep skid register keeps input accepted while a result waits, so the
// input stalls only when two bytes' results are pending. Window registers are
// written over the APB port and must be stable while a mask is streaming.
module mask_run_length_span_decoder import mrlsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] mask_byte_i,
  input  logic             end_of_mask_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       kind_o,
  output logic [PosW-1:0]  row_o,
  output logic [PosW-1:0]  column_o,
  output logic [CfgW-1:0]  span_length_o,
  output logic             last_o
);

  cfg_t    cfg;
  pair_t   new_pair;
  logic    in_fire, push;
  pair_t   out_q, out_d, skid_q, skid_d;
  logic    out_valid_q, out_valid_d;
  logic    sel_q, sel_d;
  logic    skid_valid_q, skid_valid_d;
  result_t cur;
  logic    cur_last, out_pop, out_free;

  mrlsd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mrlsd_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .fire_i        (in_fire),
    .mask_byte_i   (mask_byte_i),
    .end_of_mask_i (end_of_mask_i),
    .pair_o        (new_pair)
  );

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign push       = in_fire && new_pair.any;

  assign cur      = sel_q ? out_q.second : out_q.first;
  assign cur_last = !out_q.two || sel_q;
  assign out_pop  = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || (out_pop && cur_last);

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    sel_d        = sel_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (out_pop && !cur_last) begin
      sel_d = 1'b1;
    end
    if (out_free) begin
      sel_d = 1'b0;
      priority if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (push) begin
        out_d       = new_pair;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push) begin
      skid_d       = new_pair;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      sel_q        <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      sel_q        <= sel_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = cur.kind;
  assign row_o         = cur.row;
  assign column_o      = cur.column;
  assign span_length_o = cur.span_length;
  assign last_o        = cur_last;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a transaction while output register is empty");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_SPAN) |-> last_o)
    else $error("status result not marked last");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_SPAN) |->
      (row_o == '0 && column_o == '0 && span_length_o == '0))
    else $error("status result carries span fields");

  a_span_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_SPAN) |-> (span_length_o != '0))
    else $error("empty span delivered");

  a_second_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && sel_q) |-> (kind_o != KIND_SPAN))
    else $error("second result of a byte is not a status");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mrlsd_pkg::*;

  typedef enum logic {
    STEP_BYTE,
    STEP_CFG
  } step_e;

  typedef struct packed {
    step_e           act;
    reg_e            idx;
    logic [CfgW-1:0] value;
    logic            eom;
    logic            typed;
    result_t         want;
  } step_t;

  typedef struct packed {
    result_t res;
    logic    last;
  } outcome_t;

  typedef struct {
    phase_e          phase;
    logic [CfgW-1:0] rows_done;
    logic [CfgW-1:0] column_pos;
    logic [7:0]      parity;
    logic            status_given;
  } decode_state_t;

  localparam int unsigned RandomBytes = 1150;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [AddrW-1:0] paddr         = '0;
  logic [DataW-1:0] pwdata        = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [ByteW-1:0] mask_byte_i   = '0;
  logic             end_of_mask_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic [1:0]       kind_o;
  logic [PosW-1:0]  row_o;
  logic [PosW-1:0]  column_o;
  logic [CfgW-1:0]  span_length_o;
  logic             last_o;

  cfg_t          regs;
  decode_state_t dec;
  outcome_t      decoded_results [$];
  step_t         plan [$];

  int  mismatches = 0;
  int  gap_next   = 0;
  int  out_hold   = 0;
  bit  in_calm    = 1'b0;
  bit  out_calm   = 1'b0;
  int  spans_seen = 0;
  int  oks_seen   = 0;
  int  errs_seen  = 0;

  mask_run_length_span_decoder dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic int draw_idle(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic result_t make_result(input kind_e k, input int unsigned r,
                                          input int unsigned c, input int unsigned len);
    result_t x;
    x.kind        = k;
    x.row         = PosW'(r);
    x.column      = PosW'(c);
    x.span_length = CfgW'(len);
    return x;
  endfunction

  function automatic step_t byte_step(input logic [ByteW-1:0] b, input logic eom);
    return '{STEP_BYTE, REG_FRAME_WIDTH, CfgW'(b), eom, 1'b0, '0};
  endfunction

  function automatic step_t typed_step(input logic [ByteW-1:0] b, input logic eom,
                                       input result_t want);
    return '{STEP_BYTE, REG_FRAME_WIDTH, CfgW'(b), eom, 1'b1, want};
  endfunction

  function automatic step_t reg_step(input reg_e r, input int unsigned v);
    return '{STEP_CFG, r, CfgW'(v), 1'b0, 1'b0, '0};
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 50) $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic void restart_decode();
    dec.phase        = PH_PARITY;
    dec.rows_done    = '0;
    dec.column_pos   = '0;
    dec.parity       = '0;
    dec.status_given = 1'b0;
  endfunction

  function automatic logic window_valid();
    int unsigned fw = regs.frame_width;
    int unsigned fh = regs.frame_height;
    int unsigned wx = regs.win_x;
    int unsigned wy = regs.win_y;
    if (fw > MaxDim || fh > MaxDim) return 1'b0;
    if (wx > fw || wy > fh) return 1'b0;
    if (regs.win_width > fw - wx) return 1'b0;
    if (regs.win_height > fh - wy) return 1'b0;
    return 1'b1;
  endfunction

  // Advances the decode state by one mask byte and queues the results it causes.
  function automatic void decode_mask_byte(input logic [ByteW-1:0] b, input logic eom,
                                           input logic typed, input result_t want);
    result_t     made [$];
    logic        have_run = 1'b0;
    logic        row_done = 1'b0;
    int unsigned run_len  = 0;
    int unsigned room;
    int unsigned vis;
    if (!dec.status_given) begin
      if (!window_valid()) begin
        made.push_back(make_result(KIND_ERR, 0, 0, 0));
        dec.status_given = 1'b1;
      end else if (dec.rows_done >= regs.win_height) begin
        made.push_back(make_result(KIND_OK, 0, 0, 0));
        dec.status_given = 1'b1;
      end else begin
        case (dec.phase)
          PH_PARITY: begin
            dec.parity     = b;
            dec.column_pos = '0;
            if (regs.win_width == 0) row_done = 1'b1;
            else dec.phase = PH_RUN;
          end
          PH_RUN: begin
            if (b != 0) begin
              run_len  = b;
              have_run = 1'b1;
            end else begin
              dec.phase = PH_EXT;
            end
          end
          PH_EXT: begin
            if (regs.frame_width == ShortExtWidth) begin
              run_len  = RunExtBase + ((int'(b) + 1) % 256);
              have_run = 1'b1;
            end else if (b == ByteMax) begin
              run_len  = RunThirdBase;
              have_run = 1'b1;
            end else if (b != 0) begin
              run_len  = RunLongBase + b;
              have_run = 1'b1;
            end else begin
              dec.phase = PH_THIRD;
            end
          end
          default: begin
            run_len  = RunThirdBase + ((int'(b) + 1) % 256);
            have_run = 1'b1;
          end
        endcase

        if (have_run) begin
          room = (dec.column_pos < regs.win_width) ? regs.win_width - dec.column_pos : 0;
          vis  = (run_len < room) ? run_len : room;
          if (dec.parity < 8'd128 && vis > 0) begin
            made.push_back(make_result(KIND_SPAN, regs.win_y + dec.rows_done,
                                       regs.win_x + dec.column_pos, vis));
          end
          dec.column_pos = CfgW'(dec.column_pos + vis);
          dec.parity     = -dec.parity;
          if (dec.column_pos >= regs.win_width) row_done = 1'b1;
          else dec.phase = PH_RUN;
        end

        if (row_done) begin
          dec.rows_done  = dec.rows_done + 1'b1;
          dec.column_pos = '0;
          dec.phase      = PH_PARITY;
          if (dec.rows_done >= regs.win_height) begin
            made.push_back(make_result(KIND_OK, 0, 0, 0));
            dec.status_given = 1'b1;
          end
        end

        if (!dec.status_given && eom) begin
          made.push_back(make_result(dec.phase == PH_PARITY ? KIND_OK : KIND_ERR, 0, 0, 0));
          dec.status_given = 1'b1;
        end
      end
    end
    if (eom) restart_decode();
    if (typed) made = '{want};
    foreach (made[i]) decoded_results.push_back('{made[i], logic'(i == made.size() - 1)});
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input logic eom, input logic typed,
                           input result_t want);
    repeat (gap_next) @(posedge clk_i);
    in_valid_i    <= 1'b1;
    mask_byte_i   <= b;
    end_of_mask_i <= eom;
    do @(posedge clk_i); while (in_stall_o);
    decode_mask_byte(b, eom, typed, want);
    gap_next = draw_idle(in_calm);
    if (gap_next > 0) in_valid_i <= 1'b0;
  endtask

  // Holds the input back until every queued result has been delivered.
  task automatic drain();
    if (gap_next == 0) begin
      in_valid_i <= 1'b0;
      gap_next = 1;
    end
    while (decoded_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e r, input logic [CfgW-1:0] v);
    logic [DataW-1:0] back;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({r, 2'b00});
    pwdata  <= DataW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    back = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (back !== DataW'(v)) report($sformatf("register %s read %0d, wrote %0d",
                                             r.name(), back, v));
    case (r)
      REG_FRAME_WIDTH:  regs.frame_width  = v;
      REG_FRAME_HEIGHT: regs.frame_height = v;
      REG_WIN_X:        regs.win_x        = v;
      REG_WIN_Y:        regs.win_y        = v;
      REG_WIN_WIDTH:    regs.win_width    = v;
      REG_WIN_HEIGHT:   regs.win_height   = v;
      default: ;
    endcase
  endtask

  task automatic randomize_window();
    int unsigned fw;
    int unsigned fh;
    int unsigned wx;
    int unsigned wy;
    int unsigned ww;
    int unsigned wh;
    int unsigned room_w;
    int unsigned room_h;
    case ($urandom_range(0, 9))
      0:          fw = 0;
      1:          fw = MaxDim;
      2, 3, 4, 5: fw = ShortExtWidth;
      default:    fw = $urandom_range(1, MaxDim);
    endcase
    fh = ($urandom_range(0, 9) == 0) ? int'(MaxDim) : $urandom_range(0, 64);
    wx = $urandom_range(0, 1) ? 0 : $urandom_range(0, fw);
    wy = $urandom_range(0, 1) ? 0 : $urandom_range(0, fh);
    room_w = fw - wx;
    room_h = fh - wy;
    case ($urandom_range(0, 6))
      0:       ww = room_w;
      1:       ww = $urandom_range(0, room_w);
      default: ww = $urandom_range(0, room_w < 40 ? room_w : 40);
    endcase
    wh = $urandom_range(0, room_h < 5 ? room_h : 5);
    if ($urandom_range(0, 9) == 0) begin
      if (room_w < MaxDim) ww = $urandom_range(room_w + 1, MaxDim);
      else if (room_h < MaxDim) wh = $urandom_range(room_h + 1, MaxDim);
    end
    write_reg(REG_FRAME_WIDTH, CfgW'(fw));
    write_reg(REG_FRAME_HEIGHT, CfgW'(fh));
    write_reg(REG_WIN_X, CfgW'(wx));
    write_reg(REG_WIN_Y, CfgW'(wy));
    write_reg(REG_WIN_WIDTH, CfgW'(ww));
    write_reg(REG_WIN_HEIGHT, CfgW'(wh));
  endtask

  always @(posedge clk_i) begin : result_watch
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      case (kind_o)
        KIND_SPAN: spans_seen++;
        KIND_OK:   oks_seen++;
        default:   errs_seen++;
      endcase
      if (decoded_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d row %0d col %0d len %0d last %0b",
                         kind_o, row_o, column_o, span_length_o, last_o));
      end else begin
        want = decoded_results.pop_front();
        if ({kind_o, row_o, column_o, span_length_o, last_o} !== want) begin
          report($sformatf({"got kind %0d row %0d col %0d len %0d last %0b, ",
                            "want kind %0d row %0d col %0d len %0d last %0b"},
                           kind_o, row_o, column_o, span_length_o, last_o,
                           want.res.kind, want.res.row, want.res.column,
                           want.res.span_length, want.last));
        end
      end
      out_hold = draw_idle(out_calm);
    end else if (out_hold > 0) begin
      out_hold--;
    end
    out_stall_i <= (out_hold > 0);
  end

  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int unsigned     random_bytes;
    int unsigned     masks;
    int unsigned     windows;
    logic [ByteW-1:0] b;
    logic            e;
    logic            at_mask_start;
    random_bytes  = 0;
    masks         = 0;
    windows       = 0;
    at_mask_start = 1'b1;
    regs = '{FrameWidthRst, FrameHeightRst, '0, '0, WinWidthRst, WinHeightRst};
    restart_decode();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan = '{
      // reset window: 320 wide frame, short extension form
      byte_step(8'h7F, 1'b0),
      typed_step(8'hFF, 1'b0, make_result(KIND_SPAN, 0, 0, 255)),
      byte_step(8'h00, 1'b0),
      byte_step(8'h00, 1'b0),
      typed_step(8'h00, 1'b1, make_result(KIND_ERR, 0, 0, 0)),
      byte_step(8'h00, 1'b0),
      typed_step(8'h00, 1'b1, make_result(KIND_ERR, 0, 0, 0)),
      // full 1024 frame, long run forms, bottom two rows
      reg_step(REG_FRAME_WIDTH, 1024),
      reg_step(REG_FRAME_HEIGHT, 1024),
      reg_step(REG_WIN_Y, 1022),
      reg_step(REG_WIN_WIDTH, 1024),
      reg_step(REG_WIN_HEIGHT, 2),
      byte_step(8'h00, 1'b0),
      byte_step(8'h00, 1'b0),
      byte_step(8'hFF, 1'b0),
      byte_step(8'h00, 1'b0),
      byte_step(8'h00, 1'b0),
      byte_step(8'hFE, 1'b0),
      byte_step(8'h01, 1'b0),
      byte_step(8'h00, 1'b0),
      byte_step(8'h01, 1'b0),
      byte_step(8'h00, 1'b0),
      byte_step(8'h00, 1'b0),
      byte_step(8'hFF, 1'b0),
      byte_step(8'h00, 1'b0),
      byte_step(8'hFF, 1'b0),
      byte_step(8'h44, 1'b1),
      // zero height, then zero width
      reg_step(REG_WIN_HEIGHT, 0),
      typed_step(8'hAA, 1'b1, make_result(KIND_OK, 0, 0, 0)),
      reg_step(REG_WIN_WIDTH, 0),
      reg_step(REG_WIN_HEIGHT, 1),
      typed_step(8'h80, 1'b1, make_result(KIND_OK, 0, 0, 0)),
      // window sticks out of the frame
      reg_step(REG_WIN_X, 1),
      reg_step(REG_WIN_WIDTH, 1024),
      typed_step(8'h12, 1'b1, make_result(KIND_ERR, 0, 0, 0)),
      // window narrowed in the middle of a row
      reg_step(REG_WIN_X, 0),
      reg_step(REG_WIN_Y, 0),
      byte_step(8'h00, 1'b0),
      byte_step(8'h10, 1'b0),
      reg_step(REG_WIN_WIDTH, 8),
      byte_step(8'h05, 1'b1)
    };

    foreach (plan[i]) begin
      if (plan[i].act == STEP_CFG) begin
        drain();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_byte(plan[i].value[ByteW-1:0], plan[i].eom, plan[i].typed, plan[i].want);
      end
    end

    while (random_bytes < RandomBytes) begin
      if (at_mask_start && (windows == 0 || $urandom_range(0, 3) == 0)) begin
        drain();
        randomize_window();
        windows++;
      end
      if ($urandom_range(0, 149) == 0) drain();
      case ($urandom_range(0, 9))
        0, 1:    b = '0;
        2:       b = ByteMax;
        3:       b = ByteW'($urandom_range(1, 4));
        default: b = ByteW'($urandom);
      endcase
      if (dec.status_given) e = 1'($urandom_range(0, 1));
      else if (dec.phase == PH_PARITY && dec.rows_done != 0) e = ($urandom_range(0, 2) == 0);
      else e = ($urandom_range(0, 59) == 0);
      random_bytes++;
      send_byte(b, e, 1'b0, make_result(KIND_SPAN, 0, 0, 0));
      at_mask_start = e;
      if (e) masks++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("%0d directed steps, %0d random mask bytes in %0d masks over %0d windows",
             plan.size(), random_bytes, masks, windows);
    $display("delivered %0d spans, %0d ok and %0d error statuses",
             spans_seen, oks_seen, errs_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
